[hdl/mqmf_pkg.sv]
// ----------------------------------------------------------------------------
// mqmf_pkg
// Shared types, constants and helpers of the multi-queue message fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package mqmf_pkg;

    localparam int MSG_W      = 64;
    localparam int QID_W      = 2;
    localparam int DEPTH_W    = 5;
    localparam int BYTES_W    = 4;
    localparam int REG_QUEUES = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);
    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(8);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_Q0_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q1_DEPTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q2_DEPTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Q3_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q0_BYTES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Q1_BYTES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Q2_BYTES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Q3_BYTES = 3'd7;

    // operation codes
    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef struct packed {
        logic             func;
        logic [QID_W-1:0] queue_id;
        logic [MSG_W-1:0] message_in;
    } mqmf_in_t;

    typedef struct packed {
        logic             ok;
        logic [MSG_W-1:0] message_out;
    } mqmf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } mqmf_state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic mod_start;
        logic mod_step;
        logic mem_read;
        logic mem_write;
        logic out_load;
    } mqmf_cmd_t;

    typedef struct packed {
        logic pass;
        logic is_put;
        logic mod_last;
        logic out_busy;
    } mqmf_sts_t;

    function automatic logic [MSG_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
        logic [MSG_W-1:0] m;
        m = '0;
        for (int i = 0; i < MSG_W / 8; i++) begin
            if (BYTES_W'(i) < nbytes) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hdl/mqmf_ctrl.sv]
// ----------------------------------------------------------------------------
// mqmf_ctrl
// Sequencer: takes one operation, steps the datapath through check,
// slot remainder (puts only), memory access and result load; a failed check goes to result load.
// ----------------------------------------------------------------------------
`default_nettype none

module mqmf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mqmf_pkg::mqmf_sts_t sts,
    output mqmf_pkg::mqmf_cmd_t      cmd
);
    import mqmf_pkg::*;

    mqmf_state_t state_reg;
    mqmf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (!sts.pass) begin
                    state_next = ST_FINISH;
                end else if (sts.is_put) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end else begin
                    // read is issued and head/count move in the same cycle
                    cmd.mem_read = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.mem_write = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_READ: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/mqmf_dpath.sv]
// ----------------------------------------------------------------------------
// mqmf_dpath
// Datapath: configuration registers, per-queue head and fill count,
// bit-serial slot remainder, message memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqmf_dpath #(
    parameter int NUM_QUEUES = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int MAX_BYTES  = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mqmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mqmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire mqmf_pkg::mqmf_in_t                  s_data,
    input  wire mqmf_pkg::mqmf_cmd_t                 cmd,
    output mqmf_pkg::mqmf_sts_t                      sts,
    input  wire logic                                m_ready,
    output logic                                     m_valid,
    output mqmf_pkg::mqmf_out_t                      m_data
);
    import mqmf_pkg::*;

    localparam int HEAD_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CMP_W     = ((HEAD_W > DEPTH_W) ? HEAD_W : DEPTH_W) + 1;
    localparam int SUM_W     = CMP_W;
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * MAX_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // configuration
    logic [DEPTH_W-1:0] depth_reg [REG_QUEUES];
    logic [DEPTH_W-1:0] depth_next [REG_QUEUES];
    logic [BYTES_W-1:0] bytes_reg [REG_QUEUES];
    logic [BYTES_W-1:0] bytes_next [REG_QUEUES];

    // per-queue pointers
    logic [HEAD_W-1:0]  head_reg [NUM_QUEUES];
    logic [HEAD_W-1:0]  head_next [NUM_QUEUES];
    logic [DEPTH_W-1:0] cnt_reg [NUM_QUEUES];
    logic [DEPTH_W-1:0] cnt_next [NUM_QUEUES];

    // latched operation
    logic             func_reg;
    logic [QID_W-1:0] qid_reg;
    logic [MSG_W-1:0] msg_reg;
    logic             ok_reg;
    logic             ok_next;

    // slot remainder unit
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [DEPTH_W-1:0] rem_reg;
    logic [DEPTH_W-1:0] rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    // memory
    logic [MSG_W-1:0]  mem [MEM_DEPTH];
    logic [MSG_W-1:0]  rdata_reg;

    logic      m_valid_reg;
    logic      m_valid_next;
    mqmf_out_t m_data_reg;
    mqmf_out_t m_data_next;

    logic [QSEL_W-1:0]  qsel;
    logic               q_valid;
    logic [DEPTH_W-1:0] depth_eff;
    logic [BYTES_W-1:0] bytes_eff;
    logic [MSG_W-1:0]   mask;
    logic [HEAD_W-1:0]  head_cur;
    logic [DEPTH_W-1:0] cnt_cur;
    logic               full;
    logic               empty;
    logic [CMP_W-1:0]   head_inc;
    logic [HEAD_W-1:0]  head_adv;
    logic [DEPTH_W:0]   trial;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    assign qsel     = qid_reg[QSEL_W-1:0];
    assign q_valid  = ({1'b0, qid_reg} < (QID_W + 1)'(NUM_QUEUES));
    assign head_cur = head_reg[qsel];
    assign cnt_cur  = cnt_reg[qsel];

    assign depth_eff = (int'(depth_reg[qid_reg]) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                              : depth_reg[qid_reg];
    assign bytes_eff = (bytes_reg[qid_reg] > BYTES_W'(MAX_BYTES)) ? BYTES_W'(MAX_BYTES)
                                                                  : bytes_reg[qid_reg];
    assign mask = byte_mask(bytes_eff);

    assign full  = (cnt_cur >= depth_eff);
    assign empty = (cnt_cur == '0);

    // head wraps to zero once it reaches the depth
    assign head_inc = CMP_W'(head_cur) + CMP_W'(1);
    assign head_adv = (head_inc >= CMP_W'(depth_eff)) ? '0 : HEAD_W'(head_inc);

    // one restoring remainder step per cycle, msb of the sum first
    assign trial = {rem_reg, sum_reg[SUM_W-1]};

    assign base_addr = ADDR_W'(qsel) * ADDR_W'(MAX_DEPTH);
    assign rd_addr   = base_addr + ADDR_W'(head_cur);
    assign wr_addr   = base_addr + ADDR_W'(rem_reg);

    assign sts.pass     = q_valid && ((func_reg == FUNC_PUT) ? !full : !empty);
    assign sts.is_put   = (func_reg == FUNC_PUT);
    assign sts.mod_last = (step_reg == STEP_W'(1));
    assign sts.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        depth_next   = depth_reg;
        bytes_next   = bytes_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_Q0_DEPTH: depth_next[0] = cfg_wdata[DEPTH_W-1:0];
                REG_Q1_DEPTH: depth_next[1] = cfg_wdata[DEPTH_W-1:0];
                REG_Q2_DEPTH: depth_next[2] = cfg_wdata[DEPTH_W-1:0];
                REG_Q3_DEPTH: depth_next[3] = cfg_wdata[DEPTH_W-1:0];
                REG_Q0_BYTES: bytes_next[0] = cfg_wdata[BYTES_W-1:0];
                REG_Q1_BYTES: bytes_next[1] = cfg_wdata[BYTES_W-1:0];
                REG_Q2_BYTES: bytes_next[2] = cfg_wdata[BYTES_W-1:0];
                REG_Q3_BYTES: bytes_next[3] = cfg_wdata[BYTES_W-1:0];
                default: begin
                end
            endcase
        end

        if (cmd.check) begin
            ok_next = sts.pass;
        end

        if (cmd.mem_read) begin
            head_next[qsel] = head_adv;
            cnt_next[qsel]  = cnt_cur - DEPTH_W'(1);
        end

        if (cmd.mod_start) begin
            sum_next  = SUM_W'(head_cur) + SUM_W'(cnt_cur);
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
        end else if (cmd.mod_step) begin
            sum_next  = {sum_reg[SUM_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (trial >= {1'b0, depth_eff}) begin
                rem_next = DEPTH_W'(trial - {1'b0, depth_eff});
            end else begin
                rem_next = trial[DEPTH_W-1:0];
            end
        end

        if (cmd.mem_write) begin
            cnt_next[qsel] = cnt_cur + DEPTH_W'(1);
        end

        if (cmd.out_load) begin
            m_valid_next   = 1'b1;
            m_data_next.ok = ok_reg;
            if (ok_reg && (func_reg == FUNC_GET)) begin
                m_data_next.message_out = rdata_reg & mask;
            end else begin
                m_data_next.message_out = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_QUEUES; i++) begin
                depth_reg[i] <= DEPTH_RESET;
                bytes_reg[i] <= BYTES_RESET;
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            bytes_reg   <= bytes_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_data.func;
            qid_reg  <= s_data.queue_id;
            msg_reg  <= s_data.message_in;
        end
        ok_reg     <= ok_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    // message store: stored bytes are masked to the size at put time
    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[wr_addr] <= msg_reg & mask;
        end
        if (cmd.mem_read) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[hdl/multi_queue_message_fifo_unit.sv]
// One operation is in flight at a time; the next beat is taken the cycle after the result
// is loaded, and a stalled result holds the input off.
// A put's slot comes from a bit-serial remainder unit, one sum bit per cycle (SUM_W is 6
// at the default sizes).
// Reset clears heads, counts and output valid, sets depths to 16 and sizes to 8 bytes.
// ----------------------------------------------------------------------------
// multi_queue_message_fifo_unit
// Several ring-buffer queues of fixed-size messages with put and get
// operations, per-queue depth and message size registers.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_message_fifo_unit #(
    parameter int NUM_QUEUES = 4,
    parameter int MAX_DEPTH  = 16,
    parameter int MAX_BYTES  = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mqmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mqmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mqmf_pkg::mqmf_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mqmf_pkg::mqmf_out_t                  m_data
);
    import mqmf_pkg::*;

    mqmf_cmd_t cmd;
    mqmf_sts_t sts;

    mqmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mqmf_dpath #(
        .NUM_QUEUES (NUM_QUEUES),
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_BYTES  (MAX_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
